// ----- src/cce_pkg.sv -----
// Shared types, key and field codes, and the month-length function for the
// clock/calendar field editor. Depends on nothing.
package cce_pkg;

  localparam logic [2:0] KEY_NONE   = 3'd0;
  localparam logic [2:0] KEY_TOGGLE = 3'd1;
  localparam logic [2:0] KEY_NEXT   = 3'd2;
  localparam logic [2:0] KEY_UP     = 3'd3;
  localparam logic [2:0] KEY_DOWN   = 3'd4;

  localparam logic [2:0] FLD_YEAR   = 3'd0;
  localparam logic [2:0] FLD_MONTH  = 3'd1;
  localparam logic [2:0] FLD_DAY    = 3'd2;
  localparam logic [2:0] FLD_HOUR   = 3'd3;
  localparam logic [2:0] FLD_MINUTE = 3'd4;
  localparam logic [2:0] FLD_SECOND = 3'd5;
  localparam int unsigned NUM_FIELDS = 6;

  typedef struct packed {
    logic [2:0] mode;
    logic [6:0] read_year;
    logic [3:0] read_month;
    logic [4:0] read_day;
    logic [4:0] read_hour;
    logic [5:0] read_minute;
    logic [5:0] read_second;
  } in_item_t;

  typedef struct packed {
    logic       in_set_mode;
    logic [2:0] selected_field;
    logic [6:0] out_year;
    logic [3:0] out_month;
    logic [4:0] out_day;
    logic [4:0] out_hour;
    logic [5:0] out_minute;
    logic [5:0] out_second;
    logic       write_clock;
  } out_item_t;

  typedef struct packed {
    logic       editing;
    logic [2:0] field;
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } cce_state_t;

  // Days in month; any month value outside 1..12 counts as 30.
  function automatic logic [4:0] month_len(input logic signed [7:0] m,
                                           input logic [1:0] year_lo);
    logic [4:0] len;
    begin
      if (m == 8'sd1 || m == 8'sd3 || m == 8'sd5 || m == 8'sd7 ||
          m == 8'sd8 || m == 8'sd10 || m == 8'sd12) begin
        len = 5'd31;
      end else if (m == 8'sd2) begin
        len = (year_lo == 2'd0) ? 5'd29 : 5'd28;
      end else begin
        len = 5'd30;
      end
      return len;
    end
  endfunction

endpackage

// ----- src/cce_step.sv -----
// Single-pass step logic: key decode, field edit with wraps, day check.
// Depends on cce_pkg.
module cce_step (
  input  cce_pkg::cce_state_t st,
  input  cce_pkg::in_item_t   item,
  output cce_pkg::cce_state_t st_nxt,
  output cce_pkg::out_item_t  res
);
  import cce_pkg::*;

  logic              editing;
  logic              up;
  logic signed [7:0] delta;
  logic signed [7:0] v_year, v_month, v_day, v_hour, v_minute, v_second;
  logic signed [7:0] len_s;
  logic [3:0]        field_inc;
  cce_state_t        edited;

  always_comb begin
    up       = (item.mode == KEY_UP);
    delta    = up ? 8'sd1 : -8'sd1;
    v_year   = signed'({1'b0, st.year});
    v_month  = signed'({4'b0, st.month});
    v_day    = signed'({3'b0, st.day});
    v_hour   = signed'({3'b0, st.hour});
    v_minute = signed'({2'b0, st.minute});
    v_second = signed'({2'b0, st.second});

    case (st.field)
      FLD_YEAR:   v_year   = v_year + delta;
      FLD_MONTH:  v_month  = v_month + delta;
      FLD_DAY:    v_day    = v_day + delta;
      FLD_HOUR:   v_hour   = v_hour + delta;
      FLD_MINUTE: v_minute = v_minute + delta;
      FLD_SECOND: v_second = v_second + delta;
      default:    ;
    endcase

    // Day wraps both ways; others wrap only in the direction used, else stay.
    if (up) begin
      if (v_year > 8'sd99) v_year = 8'sd0;
      if (v_month > 8'sd12) v_month = 8'sd1;
    end else begin
      if (v_year < 8'sd0) v_year = 8'sd99;
      if (v_month < 8'sd1) v_month = 8'sd12;
    end
    len_s = signed'({3'b0, month_len(v_month, v_year[1:0])});
    if (v_day < 8'sd1) v_day = len_s;
    if (v_day > len_s) v_day = 8'sd1;
    if (up) begin
      if (v_hour > 8'sd23) v_hour = 8'sd0;
      if (v_minute > 8'sd59) v_minute = 8'sd0;
      if (v_second > 8'sd59) v_second = 8'sd0;
    end else begin
      if (v_hour < 8'sd0) v_hour = 8'sd23;
      if (v_minute < 8'sd0) v_minute = 8'sd59;
      if (v_second < 8'sd0) v_second = 8'sd59;
    end

    edited        = st;
    edited.year   = v_year[6:0];
    edited.month  = v_month[3:0];
    edited.day    = v_day[4:0];
    edited.hour   = v_hour[4:0];
    edited.minute = v_minute[5:0];
    edited.second = v_second[5:0];

    field_inc = {1'b0, st.field} + 4'd1;
    if (field_inc >= 4'(NUM_FIELDS)) field_inc = field_inc - 4'(NUM_FIELDS);

    editing = st.editing ^ (item.mode == KEY_TOGGLE);
    st_nxt  = st;
    st_nxt.editing = editing;
    if (!editing) begin
      st_nxt.year   = item.read_year;
      st_nxt.month  = item.read_month;
      st_nxt.day    = item.read_day;
      st_nxt.hour   = item.read_hour;
      st_nxt.minute = item.read_minute;
      st_nxt.second = item.read_second;
    end else begin
      case (item.mode)
        KEY_NEXT: st_nxt.field = field_inc[2:0];
        KEY_UP,
        KEY_DOWN: st_nxt = edited;
        default:  ;
      endcase
      st_nxt.editing = editing;
    end

    res.in_set_mode    = st_nxt.editing;
    res.selected_field = st_nxt.field;
    res.out_year       = st_nxt.year;
    res.out_month      = st_nxt.month;
    res.out_day        = st_nxt.day;
    res.out_hour       = st_nxt.hour;
    res.out_minute     = st_nxt.minute;
    res.out_second     = st_nxt.second;
    res.write_clock    = editing;
  end

endmodule

// ----- src/clock_calendar_field_editor.sv -----
// Top level of the clock/calendar field editor: input register, state and
// result register around cce_step. Depends on cce_pkg and cce_step.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | in_item  (key code + clock reading)
//  out_    | output    | out_valid/out_stall| out_item (registers, field, strobe)
//
// Items pass the input, then the result register; one per cycle sustained while
// out_stall is low. The step logic and the editor state update in the cycle an
// item leaves the input register, so each item sees the state left by the one
// before. A stalled result holds the input register; in_stall rises only
// when both stages are full. Reset gives show mode, field 0, 00-01-01 00:00:00.
module clock_calendar_field_editor (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cce_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output cce_pkg::out_item_t out_item
);
  import cce_pkg::*;

  logic       in_vld_r;
  in_item_t   in_item_r;
  logic       out_vld_r;
  out_item_t  out_item_r;
  cce_state_t st_r;
  cce_state_t st_nxt;
  out_item_t  res;
  logic       out_free;
  logic       fire;

  assign out_free = !out_vld_r || !out_stall;
  assign fire     = in_vld_r && out_free;
  assign in_stall = in_vld_r && !out_free;

  cce_step u_step (
    .st     (st_r),
    .item   (in_item_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      st_r      <= '{editing: 1'b0, field: FLD_YEAR, year: 7'd0, month: 4'd1,
                     day: 5'd1, hour: 5'd0, minute: 6'd0, second: 6'd0};
    end else begin
      if (!in_stall) in_vld_r <= in_valid;
      if (out_free) out_vld_r <= fire;
      if (fire) st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_item_r <= in_item;
    if (fire) out_item_r <= res;
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

  a_strobe_follows_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.write_clock == out_item.in_set_mode)
    else $error("write strobe does not match set mode");

  a_field_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.selected_field < 3'(NUM_FIELDS))
    else $error("selected field out of range");

  a_state_held_while_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(st_r))
    else $error("editor state changed without an item");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_vld_r && out_vld_r))
    else $error("input stalled with a free stage");

endmodule
